### sv/base64_stream_codec_unit_defines.svh
// ----------------------------------------------------------------------------
// base64_stream_codec_unit_defines.svh
// Assertion macros used by the checker of the base64 stream codec.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_DEFINES_SVH
`define BASE64_STREAM_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define B64SC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define B64SC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic       REG_DIRECTION_MODE = 1'b0;  // word index, paddr[2]
  localparam logic       MODE_ENCODE        = 1'b0;
  localparam logic       MODE_DECODE        = 1'b1;
  localparam logic [7:0] PAD_CHAR           = 8'h3D;

  // One unit of back-end work: up to four result bytes from one input item.
  typedef struct packed {
    logic [3:0][7:0] data;      // data[0] goes out first
    logic [1:0]      last_idx;  // index of the last result
    logic            bare;      // end marker with no data
    logic            eom;       // last result closes the message
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] v;
  } sextet_t;

  function automatic logic [7:0] alphabet_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26)      return 8'h41 + s8;
    else if (s < 6'd52) return 8'h47 + s8;
    else if (s < 6'd62) return s8 - 8'd4;
    else if (s == 6'd62) return 8'h2B;
    else                 return 8'h2F;
  endfunction

  function automatic sextet_t sextet_decode(input logic [7:0] c);
    sextet_t    r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h47;
      r.ok = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      r.ok = 1'b1;
    end else if (c == 8'h2B) begin
      t = 8'd62;
      r.ok = 1'b1;
    end else if (c == 8'h2F) begin
      t = 8'd63;
      r.ok = 1'b1;
    end
    r.v = t[5:0];
    return r;
  endfunction

endpackage

### sv/b64sc_if.sv
// ----------------------------------------------------------------------------
// b64sc_in_if / b64sc_out_if
// Valid/ready stream channels of the base64 stream codec.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, in_byte, end_of_message, input ready);
  modport sink   (input valid, in_byte, end_of_message, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       message_done;
  logic       run_last;

  modport source (output valid, out_byte, out_valid, message_done, run_last, input ready);
  modport sink   (input valid, out_byte, out_valid, message_done, run_last, output ready);
endinterface

### sv/b64sc_front.sv
// ----------------------------------------------------------------------------
// b64sc_front
// Accept items, track the group state, queue a job per group or message end.
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic            mode,
  b64sc_in_if.sink        in_ch,
  input  logic            q_full,
  output logic            push,
  output b64sc_pkg::job_t push_job
);
  import b64sc_pkg::*;

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pad_r, pad_nxt;

  logic [23:0] enc_acc;
  logic [1:0]  enc_cnt;
  logic [23:0] dec_acc;
  sextet_t     sx;
  logic        have;
  logic        accept;
  job_t        job;
  logic [7:0]  b;
  logic        eom;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign eom         = in_ch.end_of_message;

  always_comb begin
    job     = '0;
    have    = 1'b0;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    enc_acc = {acc_r[15:0], b};
    enc_cnt = cnt_r + 2'd1;
    sx      = sextet_decode(b);
    dec_acc = {acc_r[17:0], sx.v};

    if (mode == MODE_ENCODE) begin
      acc_nxt = enc_acc;
      cnt_nxt = enc_cnt;
      if (enc_cnt == 2'd3 || enc_cnt == 2'd0) begin
        have         = 1'b1;
        job.last_idx = 2'd3;
        job.data[0]  = alphabet_char(enc_acc[23:18]);
        job.data[1]  = alphabet_char(enc_acc[17:12]);
        job.data[2]  = alphabet_char(enc_acc[11:6]);
        job.data[3]  = alphabet_char(enc_acc[5:0]);
        acc_nxt      = '0;
        cnt_nxt      = '0;
      end else if (eom && enc_cnt == 2'd1) begin
        have         = 1'b1;
        job.last_idx = 2'd3;
        job.data[0]  = alphabet_char(b[7:2]);
        job.data[1]  = alphabet_char({b[1:0], 4'b0000});
        job.data[2]  = PAD_CHAR;
        job.data[3]  = PAD_CHAR;
      end else if (eom) begin
        have         = 1'b1;
        job.last_idx = 2'd3;
        job.data[0]  = alphabet_char(enc_acc[15:10]);
        job.data[1]  = alphabet_char(enc_acc[9:4]);
        job.data[2]  = alphabet_char({enc_acc[3:0], 2'b00});
        job.data[3]  = PAD_CHAR;
      end
    end else if (!pad_r) begin
      if (b == PAD_CHAR) begin
        case (cnt_r)
          2'd2: begin
            have         = 1'b1;
            job.last_idx = 2'd0;
            job.data[0]  = acc_r[11:4];
          end
          2'd3: begin
            have         = 1'b1;
            job.last_idx = 2'd1;
            job.data[0]  = acc_r[17:10];
            job.data[1]  = acc_r[9:2];
          end
          default: ;
        endcase
        acc_nxt = '0;
        cnt_nxt = '0;
        pad_nxt = 1'b1;
      end else if (sx.ok) begin
        if (cnt_r == 2'd3) begin
          have         = 1'b1;
          job.last_idx = 2'd2;
          job.data[0]  = dec_acc[23:16];
          job.data[1]  = dec_acc[15:8];
          job.data[2]  = dec_acc[7:0];
          acc_nxt      = '0;
          cnt_nxt      = '0;
        end else begin
          acc_nxt = dec_acc;
          cnt_nxt = cnt_r + 2'd1;
        end
      end
    end

    // End of message: close the job, fall back to a bare marker, drop state
    if (eom) begin
      if (!have) begin
        job      = '0;
        job.bare = 1'b1;
      end
      job.eom = 1'b1;
      acc_nxt = '0;
      cnt_nxt = '0;
      pad_nxt = 1'b0;
    end
  end

  assign push     = accept && (have || eom);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r <= '0;
      cnt_r <= '0;
      pad_r <= 1'b0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

### sv/b64sc_fifo.sv
// ----------------------------------------------------------------------------
// b64sc_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64sc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64sc_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output b64sc_pkg::job_t head
);
  import b64sc_pkg::*;

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

### sv/b64sc_back.sv
// ----------------------------------------------------------------------------
// b64sc_back
// Step the head job into the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  b64sc_pkg::job_t head,
  output logic            pop,
  b64sc_out_if.source     out_ch
);
  import b64sc_pkg::*;

  logic [1:0] idx_r;
  logic       ovld_r;
  logic [7:0] byte_r;
  logic       dv_r, done_r, last_r;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!ovld_r || out_ch.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  assign out_ch.valid        = ovld_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.out_valid    = dv_r;
  assign out_ch.message_done = done_r;
  assign out_ch.run_last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      ovld_r <= 1'b1;
      idx_r  <= at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.data[idx_r];
      dv_r   <= !head.bare;
      done_r <= head.eom && at_last;
      last_r <= at_last;
    end
  end

endmodule

### sv/base64_stream_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming base64 codec (standard alphabet), encode or decode by register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_ch   | sink      | valid/ready          | in_byte, end_of_message
//  out_ch  | source    | valid/ready          | out_byte, out_valid, message_done,
//          |           |                      | run_last
//  cfg_*   | APB slave | psel/penable, pready | direction_mode at byte 0
//
//  An input item is taken whenever the job queue has room; the back end then
//  shows one result per cycle while out_ch is ready: four for a full encode
//  group or padded tail, three for a decoded quad, two for a pad after three
//  characters, at most one otherwise. The output register is the rate limit.
//  Synchronous active-low reset; no clearing pass, the block is ready at once.
//  A stall on out_ch fills the queue (four jobs) before in_ch drops ready.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  b64sc_in_if.sink                            in_ch,
  b64sc_out_if.source                         out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [b64sc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [b64sc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [b64sc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import b64sc_pkg::*;

  logic mode_r;
  logic cfg_wr;
  logic mode_wr;
  logic push, pop, q_full, head_valid;
  job_t push_job, head;

  // Register file: one 1-bit register, word index in paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign mode_wr    = cfg_wr && (cfg_paddr[2] == REG_DIRECTION_MODE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DIRECTION_MODE) cfg_prdata[0] = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (mode_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Front end: classify the item, update group state, queue any job it yields
  b64sc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (mode_wr),
    .mode     (mode_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple the two sides so each can stall on its own
  b64sc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: drain each job one transfer at a time
  b64sc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### sv/b64sc_checker.sv
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks of the base64 stream codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_defines.svh"

module b64sc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_vld,
  input logic       out_rdy,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       message_done,
  input logic       run_last,
  input logic       cfg_pready
);

  `B64SC_ASSERT_NEXT(a_out_hold, out_vld && !out_rdy,
    out_vld && $stable(out_byte) && $stable(out_valid) && $stable(message_done)
    && $stable(run_last), "result changed while stalled")

  `B64SC_ASSERT_NOW(a_bare_marker, out_vld && !out_valid,
    message_done && run_last && out_byte == 8'h00, "malformed bare end marker")

  `B64SC_ASSERT_NOW(a_done_last, out_vld && message_done, run_last,
    "message end not on the last result of its item")

  `B64SC_ASSERT_NOW(a_pready, 1'b1, cfg_pready, "configuration port inserted wait")

endmodule

bind base64_stream_codec_unit b64sc_checker u_b64sc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_vld      (out_ch.valid),
  .out_rdy      (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .out_valid    (out_ch.out_valid),
  .message_done (out_ch.message_done),
  .run_last     (out_ch.run_last),
  .cfg_pready   (cfg_pready)
);
